// ===== sv/rlsac_pkg.sv =====
// ----------------------------------------------------------------------------
// rlsac_pkg: shared types and constants of the radio link sender/ack controller
// Operation, command and LED codes, register map, configuration and result
// structures, and the frame prefix character tables.
// ----------------------------------------------------------------------------
package rlsac_pkg;

    // Frame limits
    localparam int MAX_FRAME  = 255;
    localparam int ACK_LEN    = 3;
    localparam int SENSOR_LEN = 21;
    localparam int CNT_W      = 9;
    localparam int CNT_SAT    = 256;

    // APB register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_RX_BYTE    = 3'd0,
        OP_TX_DONE    = 3'd1,
        OP_RX_TIMEOUT = 3'd2,
        OP_RX_ERROR   = 3'd3,
        OP_TX_TIMEOUT = 3'd4,
        OP_EMPTY      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_SENSOR = 2'd1,
        CMD_ACK    = 2'd2,
        CMD_LISTEN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LED_KEEP   = 2'd0,
        LED_OFF    = 2'd1,
        LED_TOGGLE = 2'd2
    } led_t;

    typedef enum logic [2:0] {
        REG_LISTEN     = 3'd0,
        REG_ACK_WAIT   = 3'd1,
        REG_DISCOVERY  = 3'd2,
        REG_MARGIN     = 3'd3,
        REG_WAKEUP     = 3'd4,
        REG_BACKOFF    = 3'd5,
        REG_MAX_MISSES = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam logic [15:0] LISTEN_RST     = 16'd3000;
    localparam logic [15:0] ACK_WAIT_RST   = 16'd2500;
    localparam logic [15:0] DISCOVERY_RST  = 16'd1500;
    localparam logic [15:0] MARGIN_RST     = 16'd200;
    localparam logic [15:0] WAKEUP_RST     = 16'd0;
    localparam logic [9:0]  BACKOFF_RST    = 10'd0;
    localparam logic [3:0]  MAX_MISSES_RST = 4'd5;

    typedef struct packed {
        logic [15:0] listen_ms;
        logic [15:0] ack_wait_ms;
        logic [15:0] discovery_ms;
        logic [15:0] margin_ms;
        logic [15:0] wakeup_ms;
        logic [9:0]  backoff_ms;
        logic [3:0]  max_misses;
    } cfg_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] rx_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] listen_time_ms;
        logic [17:0] delay_ms;
        logic [31:0] sequence_res;
        led_t        green_led;
        led_t        red_led;
        logic        stop_blink;
        logic        is_slave;
    } result_t;

    // "ACK" prefix
    function automatic logic [7:0] ack_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h41;
            2'd1:    c = 8'h43;
            2'd2:    c = 8'h4B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Dummy Sensor Value : " prefix
    function automatic logic [7:0] sensor_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h44;
            5'd1:    c = 8'h75;
            5'd2:    c = 8'h6D;
            5'd3:    c = 8'h6D;
            5'd4:    c = 8'h79;
            5'd5:    c = 8'h20;
            5'd6:    c = 8'h53;
            5'd7:    c = 8'h65;
            5'd8:    c = 8'h6E;
            5'd9:    c = 8'h73;
            5'd10:   c = 8'h6F;
            5'd11:   c = 8'h72;
            5'd12:   c = 8'h20;
            5'd13:   c = 8'h56;
            5'd14:   c = 8'h61;
            5'd15:   c = 8'h6C;
            5'd16:   c = 8'h75;
            5'd17:   c = 8'h65;
            5'd18:   c = 8'h20;
            5'd19:   c = 8'h3A;
            5'd20:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/rlsac_cfg.sv =====
// ----------------------------------------------------------------------------
// rlsac_cfg: configuration register file
// APB-style write/read access to the seven timing and miss-limit registers.
// ----------------------------------------------------------------------------
module rlsac_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rlsac_pkg::ADDR_W-1:0] paddr,
    input  logic [rlsac_pkg::DATA_W-1:0] pwdata,
    output logic [rlsac_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output rlsac_pkg::cfg_t              cfg
);

    rlsac_pkg::cfg_t      cfg_reg;
    rlsac_pkg::cfg_t      cfg_next;
    rlsac_pkg::reg_idx_t  idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = rlsac_pkg::reg_idx_t'(paddr[rlsac_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Decode the write word into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                rlsac_pkg::REG_LISTEN:     cfg_next.listen_ms    = pwdata[15:0];
                rlsac_pkg::REG_ACK_WAIT:   cfg_next.ack_wait_ms  = pwdata[15:0];
                rlsac_pkg::REG_DISCOVERY:  cfg_next.discovery_ms = pwdata[15:0];
                rlsac_pkg::REG_MARGIN:     cfg_next.margin_ms    = pwdata[15:0];
                rlsac_pkg::REG_WAKEUP:     cfg_next.wakeup_ms    = pwdata[15:0];
                rlsac_pkg::REG_BACKOFF:    cfg_next.backoff_ms   = pwdata[9:0];
                rlsac_pkg::REG_MAX_MISSES: cfg_next.max_misses   = pwdata[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.listen_ms    <= rlsac_pkg::LISTEN_RST;
            cfg_reg.ack_wait_ms  <= rlsac_pkg::ACK_WAIT_RST;
            cfg_reg.discovery_ms <= rlsac_pkg::DISCOVERY_RST;
            cfg_reg.margin_ms    <= rlsac_pkg::MARGIN_RST;
            cfg_reg.wakeup_ms    <= rlsac_pkg::WAKEUP_RST;
            cfg_reg.backoff_ms   <= rlsac_pkg::BACKOFF_RST;
            cfg_reg.max_misses   <= rlsac_pkg::MAX_MISSES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register on read
    always_comb
    begin
        case (idx)
            rlsac_pkg::REG_LISTEN:     prdata = {16'd0, cfg_reg.listen_ms};
            rlsac_pkg::REG_ACK_WAIT:   prdata = {16'd0, cfg_reg.ack_wait_ms};
            rlsac_pkg::REG_DISCOVERY:  prdata = {16'd0, cfg_reg.discovery_ms};
            rlsac_pkg::REG_MARGIN:     prdata = {16'd0, cfg_reg.margin_ms};
            rlsac_pkg::REG_WAKEUP:     prdata = {16'd0, cfg_reg.wakeup_ms};
            rlsac_pkg::REG_BACKOFF:    prdata = {22'd0, cfg_reg.backoff_ms};
            rlsac_pkg::REG_MAX_MISSES: prdata = {28'd0, cfg_reg.max_misses};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== sv/rlsac_core.sv =====
// ----------------------------------------------------------------------------
// rlsac_core: link state and per-word decision
// Tracks the prefix match of the frame in flight, the role, the miss counter
// and the sequence number, and forms the radio command for one word.
// ----------------------------------------------------------------------------
module rlsac_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  rlsac_pkg::item_t    item,
    input  rlsac_pkg::cfg_t     cfg,
    output logic                res_valid,
    output rlsac_pkg::result_t  res
);

    logic                       role_slave_reg;
    logic                       role_slave_next;
    logic [3:0]                 miss_count_reg;
    logic [3:0]                 miss_count_next;
    logic [31:0]                seq_count_reg;
    logic [31:0]                seq_count_next;
    logic [rlsac_pkg::CNT_W-1:0] byte_count_reg;
    logic [rlsac_pkg::CNT_W-1:0] byte_count_next;
    logic                       ack_match_reg;
    logic                       ack_match_next;
    logic                       sensor_match_reg;
    logic                       sensor_match_next;

    logic [rlsac_pkg::CNT_W-1:0] cnt_inc;
    logic                       ack_m;
    logic                       sensor_m;
    logic                       fits;
    logic                       is_ack;
    logic                       is_sensor;
    logic [16:0]                pre_tx;
    logic [17:0]                pre_tx_backoff;
    logic [3:0]                 miss_inc;

    // Running prefix match including the current byte
    always_comb
    begin
        cnt_inc = (byte_count_reg < rlsac_pkg::CNT_W'(rlsac_pkg::CNT_SAT))
                ? byte_count_reg + 1'b1 : byte_count_reg;
        ack_m = ack_match_reg &&
                !((byte_count_reg < rlsac_pkg::CNT_W'(rlsac_pkg::ACK_LEN)) &&
                  (item.rx_byte != rlsac_pkg::ack_char(byte_count_reg[1:0])));
        sensor_m = sensor_match_reg &&
                !((byte_count_reg < rlsac_pkg::CNT_W'(rlsac_pkg::SENSOR_LEN)) &&
                  (item.rx_byte != rlsac_pkg::sensor_char(byte_count_reg[4:0])));
        fits      = cnt_inc <= rlsac_pkg::CNT_W'(rlsac_pkg::MAX_FRAME);
        is_ack    = fits && ack_m && (cnt_inc >= rlsac_pkg::CNT_W'(rlsac_pkg::ACK_LEN));
        is_sensor = fits && sensor_m &&
                    (cnt_inc >= rlsac_pkg::CNT_W'(rlsac_pkg::SENSOR_LEN));
        pre_tx         = {1'b0, cfg.wakeup_ms} + {1'b0, cfg.margin_ms};
        pre_tx_backoff = {1'b0, pre_tx} + {8'd0, cfg.backoff_ms};
        miss_inc       = miss_count_reg + 4'd1;
    end

    // Decide the command and the next link state
    always_comb
    begin
        role_slave_next   = role_slave_reg;
        miss_count_next   = miss_count_reg;
        seq_count_next    = seq_count_reg;
        byte_count_next   = byte_count_reg;
        ack_match_next    = ack_match_reg;
        sensor_match_next = sensor_match_reg;
        res_valid         = 1'b0;
        res               = '0;

        case (rlsac_pkg::op_t'(item.operation))
            rlsac_pkg::OP_RX_BYTE:
            begin
                byte_count_next   = cnt_inc;
                ack_match_next    = ack_m;
                sensor_match_next = sensor_m;
                if (item.frame_end)
                begin
                    res_valid         = 1'b1;
                    byte_count_next   = '0;
                    ack_match_next    = 1'b1;
                    sensor_match_next = 1'b1;
                    if (is_sensor)
                    begin
                        res.stop_blink = 1'b1;
                        res.red_led    = rlsac_pkg::LED_OFF;
                        res.green_led  = rlsac_pkg::LED_TOGGLE;
                    end
                    else if (is_ack)
                    begin
                        res.stop_blink = 1'b1;
                        res.green_led  = rlsac_pkg::LED_OFF;
                        res.red_led    = rlsac_pkg::LED_TOGGLE;
                    end
                    if (!role_slave_reg)
                    begin
                        if (is_ack)
                        begin
                            miss_count_next  = '0;
                            res.delay_ms     = {1'b0, pre_tx};
                            res.command      = rlsac_pkg::CMD_SENSOR;
                            res.sequence_res = seq_count_reg;
                            seq_count_next   = seq_count_reg + 32'd1;
                        end
                        else
                        begin
                            if (is_sensor)
                            begin
                                role_slave_next = 1'b1;
                            end
                            res.command        = rlsac_pkg::CMD_LISTEN;
                            res.listen_time_ms = cfg.listen_ms;
                        end
                    end
                    else
                    begin
                        if (is_sensor)
                        begin
                            res.delay_ms = {1'b0, pre_tx};
                            res.command  = rlsac_pkg::CMD_ACK;
                        end
                        else
                        begin
                            role_slave_next    = 1'b0;
                            res.command        = rlsac_pkg::CMD_LISTEN;
                            res.listen_time_ms = cfg.listen_ms;
                        end
                    end
                end
            end
            rlsac_pkg::OP_TX_DONE, rlsac_pkg::OP_TX_TIMEOUT:
            begin
                byte_count_next    = '0;
                ack_match_next     = 1'b1;
                sensor_match_next  = 1'b1;
                res_valid          = 1'b1;
                res.command        = rlsac_pkg::CMD_LISTEN;
                res.listen_time_ms = role_slave_reg ? cfg.listen_ms : cfg.ack_wait_ms;
            end
            rlsac_pkg::OP_RX_TIMEOUT, rlsac_pkg::OP_RX_ERROR:
            begin
                byte_count_next   = '0;
                ack_match_next    = 1'b1;
                sensor_match_next = 1'b1;
                res_valid         = 1'b1;
                if (!role_slave_reg)
                begin
                    res.delay_ms = pre_tx_backoff;
                    if (miss_inc >= cfg.max_misses)
                    begin
                        // Too many misses: fall back to rediscovery
                        miss_count_next    = '0;
                        res.command        = rlsac_pkg::CMD_LISTEN;
                        res.listen_time_ms = cfg.discovery_ms;
                    end
                    else
                    begin
                        miss_count_next  = miss_inc;
                        res.command      = rlsac_pkg::CMD_SENSOR;
                        res.sequence_res = seq_count_reg;
                        seq_count_next   = seq_count_reg + 32'd1;
                    end
                end
                else
                begin
                    res.command        = rlsac_pkg::CMD_LISTEN;
                    res.listen_time_ms = cfg.listen_ms;
                end
            end
            rlsac_pkg::OP_EMPTY:
            begin
                // Drop any partial frame
                byte_count_next   = '0;
                ack_match_next    = 1'b1;
                sensor_match_next = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        res.is_slave = role_slave_next;
    end

    // Advance the link state once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_slave_reg   <= 1'b0;
            miss_count_reg   <= '0;
            seq_count_reg    <= '0;
            byte_count_reg   <= '0;
            ack_match_reg    <= 1'b1;
            sensor_match_reg <= 1'b1;
        end
        else if (step)
        begin
            role_slave_reg   <= role_slave_next;
            miss_count_reg   <= miss_count_next;
            seq_count_reg    <= seq_count_next;
            byte_count_reg   <= byte_count_next;
            ack_match_reg    <= ack_match_next;
            sensor_match_reg <= sensor_match_next;
        end
    end

    // The miss counter is cleared before it can wrap
    a_miss_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        miss_count_reg != 4'hF)
        else $error("miss counter reached its wrap value");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= rlsac_pkg::CNT_W'(rlsac_pkg::CNT_SAT))
        else $error("byte count above saturation");

    a_seq_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && (res.command == rlsac_pkg::CMD_SENSOR))
        |=> (seq_count_reg == $past(seq_count_reg) + 32'd1))
        else $error("sequence number not advanced after sensor frame");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(role_slave_reg) && $stable(seq_count_reg)
                   && $stable(byte_count_reg)))
        else $error("link state changed without a word");

endmodule

// ===== sv/radio_link_sender_ack_controller_unit.sv =====
// An accepted input word waits in the input register, and its result word,
// if any, in the result register. Throughput: one word per cycle unless
// the result side stalls; the input and result registers give one word of
// slack on each side, so input is taken while a result waits. Reset (rst_n
// low, asynchronous) empties both registers, restores the register defaults
// and sets sender role, zero miss and sequence counts and an empty frame.
// ----------------------------------------------------------------------------
// radio_link_sender_ack_controller_unit: sender/acknowledger link controller
// Input register, decision core, result register and the APB register file.
// ----------------------------------------------------------------------------
module radio_link_sender_ack_controller_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic [2:0]                   s_tuser,   // [2:0] operation
    input  logic                         s_tlast,   // frame_end
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] listen_time_ms, [33:16] delay_ms, [65:34] sequence_res,
    // [67:66] green_led, [69:68] red_led, [70] stop_blink, [71] is_slave
    output logic [71:0]                  m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] command
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rlsac_pkg::ADDR_W-1:0] paddr,
    input  logic [rlsac_pkg::DATA_W-1:0] pwdata,
    output logic [rlsac_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    rlsac_pkg::cfg_t     cfg;
    rlsac_pkg::item_t    item_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    rlsac_pkg::result_t  res;
    logic                res_valid;
    rlsac_pkg::result_t  out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                step;
    logic                s_accept;

    rlsac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Process the held word when the result register can take its result
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    rlsac_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Valid flags of the input and result registers
    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (step)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word and the result word
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.operation <= s_tuser;
            item_reg.rx_byte   <= s_tdata;
            item_reg.frame_end <= s_tlast;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.command;
    assign m_tdata  = {out_reg.is_slave, out_reg.stop_blink, out_reg.red_led,
                       out_reg.green_led, out_reg.sequence_res, out_reg.delay_ms,
                       out_reg.listen_time_ms};

endmodule

// ===== dv/tb_radio_link_sender_ack_controller_unit.sv =====
// ----------------------------------------------------------------------------
// tb_radio_link_sender_ack_controller_unit: self-checking bench for the link
// controller. Drives payload bytes and radio events on the input stream,
// predicts every decision word from an internal model of role, miss count,
// sequence number and prefix matching, and checks each result word field by
// field. Runs directed cases, frame length limits, then random traffic under
// three register settings, the first two with source and sink stalls.
// ----------------------------------------------------------------------------
module tb_radio_link_sender_ack_controller_unit;

    localparam logic [8*3-1:0]  ACK_TEXT    = "ACK";
    localparam logic [8*21-1:0] SENSOR_TEXT = "Dummy Sensor Value : ";

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = '0;
    logic [2:0]                     s_tuser  = '0;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [71:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rlsac_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [rlsac_pkg::DATA_W-1:0]   pwdata   = '0;
    logic [rlsac_pkg::DATA_W-1:0]   prdata;
    logic                           pready;

    // Model state of the controller
    rlsac_pkg::cfg_t    link_cfg;
    logic               role_slave;
    logic [3:0]         miss_count;
    logic [31:0]        seq_count;
    logic [8:0]         frame_len;
    logic               ack_ok;
    logic               sensor_ok;

    rlsac_pkg::result_t expected_decisions[$];
    logic [7:0]         frame_buf[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int fail_count    = 0;
    int words_sent    = 0;
    int decisions_checked = 0;
    int slave_decisions   = 0;

    radio_link_sender_ack_controller_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic logic [7:0] ack_text_char(input int i);
        return ACK_TEXT[8*(rlsac_pkg::ACK_LEN-1-i) +: 8];
    endfunction

    function automatic logic [7:0] sensor_text_char(input int i);
        return SENSOR_TEXT[8*(rlsac_pkg::SENSOR_LEN-1-i) +: 8];
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Check each result word against the oldest expected decision
    always @(posedge clk)
    begin
        rlsac_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("result word with no decision expected: command %0d", m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                compare_field("command", 32'(want.command), 32'(m_tuser));
                compare_field("listen_time_ms", 32'(want.listen_time_ms), 32'(m_tdata[15:0]));
                compare_field("delay_ms", 32'(want.delay_ms), 32'(m_tdata[33:16]));
                compare_field("sequence_res", want.sequence_res, m_tdata[65:34]);
                compare_field("green_led", 32'(want.green_led), 32'(m_tdata[67:66]));
                compare_field("red_led", 32'(want.red_led), 32'(m_tdata[69:68]));
                compare_field("stop_blink", 32'(want.stop_blink), 32'(m_tdata[70]));
                compare_field("is_slave", 32'(want.is_slave), 32'(m_tdata[71]));
                decisions_checked++;
                if (want.is_slave)
                    slave_decisions++;
            end
        end
    end

    // Work out the decision caused by one accepted input word
    task automatic predict_link_decision(input logic [2:0] op, input logic [7:0] rx,
                                         input logic last);
        rlsac_pkg::result_t d;
        logic               fits;
        logic               is_ack;
        logic               is_sensor;
        logic [17:0]        pre_tx;
        d = '0;
        pre_tx = 18'(link_cfg.wakeup_ms) + 18'(link_cfg.margin_ms);
        if (op > rlsac_pkg::OP_EMPTY)
            return;
        if (op == rlsac_pkg::OP_RX_BYTE)
        begin
            // Track both prefixes byte by byte
            if (frame_len < rlsac_pkg::ACK_LEN && rx != ack_text_char(frame_len))
                ack_ok = 1'b0;
            if (frame_len < rlsac_pkg::SENSOR_LEN && rx != sensor_text_char(frame_len))
                sensor_ok = 1'b0;
            if (frame_len < rlsac_pkg::CNT_SAT)
                frame_len++;
            if (!last)
                return;
            fits      = (frame_len <= rlsac_pkg::MAX_FRAME);
            is_ack    = fits && ack_ok && (frame_len >= rlsac_pkg::ACK_LEN);
            is_sensor = fits && sensor_ok && (frame_len >= rlsac_pkg::SENSOR_LEN);
            frame_len = '0;
            ack_ok    = 1'b1;
            sensor_ok = 1'b1;
            if (is_sensor)
            begin
                d.stop_blink = 1'b1;
                d.red_led    = rlsac_pkg::LED_OFF;
                d.green_led  = rlsac_pkg::LED_TOGGLE;
            end
            else if (is_ack)
            begin
                d.stop_blink = 1'b1;
                d.green_led  = rlsac_pkg::LED_OFF;
                d.red_led    = rlsac_pkg::LED_TOGGLE;
            end
            if (!role_slave)
            begin
                if (is_ack)
                begin
                    miss_count     = '0;
                    d.delay_ms     = pre_tx;
                    d.command      = rlsac_pkg::CMD_SENSOR;
                    d.sequence_res = seq_count;
                    seq_count      = seq_count + 32'd1;
                end
                else
                begin
                    if (is_sensor)
                        role_slave = 1'b1;
                    d.command        = rlsac_pkg::CMD_LISTEN;
                    d.listen_time_ms = link_cfg.listen_ms;
                end
            end
            else if (is_sensor)
            begin
                d.delay_ms = pre_tx;
                d.command  = rlsac_pkg::CMD_ACK;
            end
            else
            begin
                role_slave       = 1'b0;
                d.command        = rlsac_pkg::CMD_LISTEN;
                d.listen_time_ms = link_cfg.listen_ms;
            end
        end
        else
        begin
            // Any event drops a partial frame
            frame_len = '0;
            ack_ok    = 1'b1;
            sensor_ok = 1'b1;
            if (op == rlsac_pkg::OP_EMPTY)
                return;
            if (op == rlsac_pkg::OP_RX_TIMEOUT || op == rlsac_pkg::OP_RX_ERROR)
            begin
                if (!role_slave)
                begin
                    d.delay_ms = pre_tx + 18'(link_cfg.backoff_ms);
                    miss_count = miss_count + 4'd1;
                    if (miss_count >= link_cfg.max_misses)
                    begin
                        miss_count       = '0;
                        d.command        = rlsac_pkg::CMD_LISTEN;
                        d.listen_time_ms = link_cfg.discovery_ms;
                    end
                    else
                    begin
                        d.command      = rlsac_pkg::CMD_SENSOR;
                        d.sequence_res = seq_count;
                        seq_count      = seq_count + 32'd1;
                    end
                end
                else
                begin
                    d.command        = rlsac_pkg::CMD_LISTEN;
                    d.listen_time_ms = link_cfg.listen_ms;
                end
            end
            else
            begin
                d.command        = rlsac_pkg::CMD_LISTEN;
                d.listen_time_ms = role_slave ? link_cfg.listen_ms : link_cfg.ack_wait_ms;
            end
        end
        d.is_slave = role_slave;
        expected_decisions.push_back(d);
    endtask

    // Send one input word, with a random gap before it
    task automatic send_word(input logic [2:0] op, input logic [7:0] rx, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_link_decision(op, rx, last);
        if (op <= rlsac_pkg::OP_EMPTY)
            words_sent++;
    endtask

    // Send the buffered bytes; close marks the last one as frame end
    task automatic send_frame_buf(input bit close);
        for (int i = 0; i < frame_buf.size(); i++)
            send_word(rlsac_pkg::OP_RX_BYTE, frame_buf[i],
                      close && (i == frame_buf.size() - 1));
    endtask

    task automatic build_prefixed_frame(input bit sensor, input int len);
        frame_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            if (sensor && i < rlsac_pkg::SENSOR_LEN)
                frame_buf.push_back(sensor_text_char(i));
            else if (!sensor && i < rlsac_pkg::ACK_LEN)
                frame_buf.push_back(ack_text_char(i));
            else
                frame_buf.push_back(8'($urandom));
        end
    endtask

    // Hold the source until every decision is back and the pipe is empty
    task automatic settle_link();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_decisions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_link_reg(input rlsac_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] bus_word;
        mask = (idx == rlsac_pkg::REG_BACKOFF)    ? 32'h0000_03FF :
               (idx == rlsac_pkg::REG_MAX_MISSES) ? 32'h0000_000F : 32'h0000_FFFF;
        bus_word = ($urandom() & ~mask) | (value & mask);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= bus_word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            rlsac_pkg::REG_LISTEN:     link_cfg.listen_ms    = bus_word[15:0];
            rlsac_pkg::REG_ACK_WAIT:   link_cfg.ack_wait_ms  = bus_word[15:0];
            rlsac_pkg::REG_DISCOVERY:  link_cfg.discovery_ms = bus_word[15:0];
            rlsac_pkg::REG_MARGIN:     link_cfg.margin_ms    = bus_word[15:0];
            rlsac_pkg::REG_WAKEUP:     link_cfg.wakeup_ms    = bus_word[15:0];
            rlsac_pkg::REG_BACKOFF:    link_cfg.backoff_ms   = bus_word[9:0];
            rlsac_pkg::REG_MAX_MISSES: link_cfg.max_misses   = bus_word[3:0];
            default:                   ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_link_regs(input logic [15:0] listen, input logic [15:0] ack_wait,
                                     input logic [15:0] discovery, input logic [15:0] margin,
                                     input logic [15:0] wakeup, input logic [9:0] backoff,
                                     input logic [3:0] misses);
        settle_link();
        write_link_reg(rlsac_pkg::REG_LISTEN, 32'(listen));
        write_link_reg(rlsac_pkg::REG_ACK_WAIT, 32'(ack_wait));
        write_link_reg(rlsac_pkg::REG_DISCOVERY, 32'(discovery));
        write_link_reg(rlsac_pkg::REG_MARGIN, 32'(margin));
        write_link_reg(rlsac_pkg::REG_WAKEUP, 32'(wakeup));
        write_link_reg(rlsac_pkg::REG_BACKOFF, 32'(backoff));
        write_link_reg(rlsac_pkg::REG_MAX_MISSES, 32'(misses));
    endtask

    task automatic apply_reset();
        link_cfg = '{listen_ms: rlsac_pkg::LISTEN_RST,
                     ack_wait_ms: rlsac_pkg::ACK_WAIT_RST,
                     discovery_ms: rlsac_pkg::DISCOVERY_RST,
                     margin_ms: rlsac_pkg::MARGIN_RST,
                     wakeup_ms: rlsac_pkg::WAKEUP_RST,
                     backoff_ms: rlsac_pkg::BACKOFF_RST,
                     max_misses: rlsac_pkg::MAX_MISSES_RST};
        role_slave = 1'b0;
        miss_count = '0;
        seq_count  = '0;
        frame_len  = '0;
        ack_ok     = 1'b1;
        sensor_ok  = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    // Every event as sender, ignored codes, short and odd frames
    task automatic test_event_decisions();
        send_word(rlsac_pkg::OP_TX_DONE, 8'hFF, 1'b1);
        send_word(rlsac_pkg::OP_RX_TIMEOUT, 8'h00, 1'b0);
        send_word(rlsac_pkg::OP_RX_ERROR, 8'hAA, 1'b1);
        send_word(rlsac_pkg::OP_TX_TIMEOUT, 8'h55, 1'b0);
        send_word(3'd6, 8'hFF, 1'b1);
        send_word(3'd7, 8'h00, 1'b0);
        send_word(rlsac_pkg::OP_EMPTY, 8'h41, 1'b1);
        build_prefixed_frame(1'b0, 3);
        send_frame_buf(1'b1);
        // drop a partial prefix on an event
        build_prefixed_frame(1'b0, 2);
        send_frame_buf(1'b0);
        send_word(rlsac_pkg::OP_RX_TIMEOUT, 8'h00, 1'b0);
        send_word(rlsac_pkg::OP_RX_BYTE, 8'h00, 1'b1);
        send_word(rlsac_pkg::OP_RX_BYTE, 8'hFF, 1'b1);
        build_prefixed_frame(1'b0, 3);
        frame_buf.push_back(8'h80);
        send_frame_buf(1'b1);
    endtask

    // Take the receiver role, acknowledge, then fall back to sender
    task automatic test_role_exchange();
        build_prefixed_frame(1'b1, rlsac_pkg::SENSOR_LEN);
        send_frame_buf(1'b1);
        send_word(rlsac_pkg::OP_TX_DONE, 8'h00, 1'b0);
        send_word(rlsac_pkg::OP_RX_TIMEOUT, 8'h00, 1'b0);
        send_word(rlsac_pkg::OP_RX_ERROR, 8'h00, 1'b0);
        send_word(rlsac_pkg::OP_TX_TIMEOUT, 8'h00, 1'b0);
        build_prefixed_frame(1'b1, rlsac_pkg::SENSOR_LEN + 3);
        send_frame_buf(1'b1);
        send_word(rlsac_pkg::OP_EMPTY, 8'h00, 1'b0);
        build_prefixed_frame(1'b0, 3);
        send_frame_buf(1'b1);
    endtask

    // Longest frame that still counts, then two past the limit with a saturated count
    task automatic test_frame_length_limit();
        build_prefixed_frame(1'b1, rlsac_pkg::MAX_FRAME);
        send_frame_buf(1'b1);
        build_prefixed_frame(1'b1, rlsac_pkg::MAX_FRAME + 2);
        send_frame_buf(1'b1);
    endtask

    // Mostly well-formed frames and event runs, some noise and broken frames
    task automatic test_random_traffic(input int target);
        int kind;
        int n;
        int stop_at;
        bit sensor;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            kind   = $urandom_range(99);
            sensor = $urandom_range(1);
            if (kind < 28)
            begin
                build_prefixed_frame(1'b0, $urandom_range(rlsac_pkg::ACK_LEN,
                                                          rlsac_pkg::ACK_LEN + 6));
                send_frame_buf(1'b1);
            end
            else if (kind < 55)
            begin
                build_prefixed_frame(1'b1, $urandom_range(rlsac_pkg::SENSOR_LEN,
                                                          rlsac_pkg::SENSOR_LEN + 7));
                send_frame_buf(1'b1);
            end
            else if (kind < 63)
            begin
                // corrupt one prefix byte
                n = sensor ? rlsac_pkg::SENSOR_LEN : rlsac_pkg::ACK_LEN;
                build_prefixed_frame(sensor, n + $urandom_range(0, 3));
                frame_buf[$urandom_range(0, n - 1)] = 8'($urandom);
                send_frame_buf(1'b1);
            end
            else if (kind < 68)
            begin
                build_prefixed_frame(sensor,
                                     sensor ? $urandom_range(1, rlsac_pkg::SENSOR_LEN - 1)
                                            : $urandom_range(1, rlsac_pkg::ACK_LEN - 1));
                send_frame_buf(1'b1);
            end
            else if (kind < 73)
            begin
                frame_buf.delete();
                repeat ($urandom_range(1, 6))
                    frame_buf.push_back(8'($urandom));
                send_frame_buf(1'b1);
            end
            else if (kind < 80)
            begin
                // run of misses, at times long enough to reach rediscovery
                repeat ($urandom_range(1, int'(link_cfg.max_misses) + 1))
                    send_word($urandom_range(1) ? rlsac_pkg::OP_RX_TIMEOUT
                                                : rlsac_pkg::OP_RX_ERROR,
                              8'($urandom), 1'($urandom));
            end
            else if (kind < 90)
                send_word(3'($urandom_range(rlsac_pkg::OP_TX_DONE, rlsac_pkg::OP_TX_TIMEOUT)),
                          8'($urandom), 1'($urandom));
            else if (kind < 94)
                send_word(rlsac_pkg::OP_EMPTY, 8'($urandom), 1'($urandom));
            else if (kind < 97)
            begin
                build_prefixed_frame(sensor, $urandom_range(1, 5));
                send_frame_buf(1'b0);
                send_word(3'($urandom_range(rlsac_pkg::OP_TX_DONE, rlsac_pkg::OP_EMPTY)),
                          8'($urandom), 1'($urandom));
            end
            else
                send_word(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        apply_reset();

        src_idle_pct  = 22;
        sink_idle_pct = 61;
        test_event_decisions();
        test_role_exchange();
        test_frame_length_limit();
        program_link_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(0, 2000)), 10'($urandom),
                          4'($urandom_range(1, 15)));
        test_random_traffic(72);

        src_idle_pct  = 61;
        sink_idle_pct = 22;
        program_link_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 4'hF);
        test_random_traffic(72);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        program_link_regs('0, '0, '0, '0, '0, '0, '0);
        test_random_traffic(72);

        settle_link();
        $display("Covered %0d input words and %0d decisions (%0d in receiver role),",
                 words_sent, decisions_checked, slave_decisions);
        $display("frames up to 257 bytes, miss runs and four register settings.");
        if (fail_count == 0)
            $display("radio_link_sender_ack_controller_unit verification clean");
        else
            $display("radio_link_sender_ack_controller_unit verification failed");
        $finish;
    end

    // Hard stop if the link hangs
    initial
    begin
        #10_000_000;
        $display("radio_link_sender_ack_controller_unit verification failed");
        $finish;
    end

endmodule
